// File: hw/rtl/dmpq_pkg.sv
package dmpq_pkg;

  localparam int KEY_W   = 16;
  localparam int CNT_W   = 7;
  // cells per group in the first level of the match reduction
  localparam int GROUP_SIZE = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] max_key;
    logic             is_empty;
    logic [CNT_W-1:0] held_count;
    logic             rejected;
  } out_item_t;

  // queued command handed from the front to the back
  typedef struct packed {
    logic             valid;
    logic             is_remove;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

// File: hw/rtl/dmpq_front.sv
module dmpq_front
  import dmpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t push_item,
  input  logic     pop,
  output cmd_t     head,
  output logic     full
);

  in_item_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;
  logic [1:0] level_nxt;
  logic       push_ok;
  logic       pop_ok;
  in_item_t   head_item;

  assign full      = (level_r == 2'd2);
  assign push_ok   = push && !full;
  assign pop_ok    = pop && (level_r != 2'd0);
  assign head_item = slot_r[rd_ptr_r];

  // classify the head item for the back end
  always_comb begin
    head.valid     = (level_r != 2'd0);
    head.is_remove = (head_item.op == OP_REMOVE);
    head.key       = head_item.key;
  end

  always_comb begin
    level_nxt = level_r;
    case ({push_ok, pop_ok})
      2'b10:   level_nxt = level_r + 2'd1;
      2'b01:   level_nxt = level_r - 2'd1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      level_r <= level_nxt;
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: hw/rtl/dmpq_back.sv
module dmpq_back
  import dmpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output logic      pop,
  output logic      res_valid,
  output out_item_t res
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic ST_EVAL  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic                state_r;
  logic [KEY_BITS-1:0] cell_r   [CAPACITY];
  logic [KEY_BITS-1:0] cell_nxt [CAPACITY];
  logic [KEY_BITS-1:0] prev_cell [CAPACITY];
  logic [KEY_BITS-1:0] next_cell [CAPACITY];
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] key_r;
  logic                remove_r;
  logic [CAPACITY-1:0] live;
  logic [CAPACITY-1:0] keep_c;
  logic [CAPACITY-1:0] bnd_c;
  logic [CAPACITY-1:0] hit_c;
  logic [CAPACITY-1:0] keep_r;
  logic [CAPACITY-1:0] bnd_r;
  logic [GROUPS-1:0]   grp_hit_c;
  logic [GROUPS-1:0]   grp_hit_r;
  logic                found;
  logic                is_full;
  logic                do_ins;
  logic                do_rem;
  logic [KEY_BITS-1:0] max_c;
  out_item_t           res_c;
  logic                res_valid_r;
  out_item_t           res_r;

  assign key_in = KEY_BITS'(cmd.key);
  assign pop    = (state_r == ST_EVAL) && cmd.valid;

  // evaluate: every cell compares against the key at once
  // cells are kept sorted, largest first, so keep is a prefix
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]   = (count_r > CNT_BITS'(i));
      keep_c[i] = live[i] && (cmd.is_remove ? (cell_r[i] > key_in)
                                            : (cell_r[i] >= key_in));
    end
    bnd_c[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      bnd_c[i] = keep_c[i-1];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      hit_c[i] = cmd.is_remove && live[i] && bnd_c[i] && (cell_r[i] == key_in);
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_hit_c[g] = 1'b0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          grp_hit_c[g] = grp_hit_c[g] | hit_c[g * GROUP_SIZE + j];
        end
      end
    end
  end

  // apply: shift the cells past the boundary by one place
  always_comb begin
    found   = |grp_hit_r;
    is_full = (count_r == CNT_BITS'(CAPACITY));
    do_ins  = !remove_r && !is_full;
    do_rem  = remove_r && found;

    prev_cell[0] = key_r;
    for (int i = 1; i < CAPACITY; i++) begin
      prev_cell[i] = cell_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      next_cell[i] = cell_r[i+1];
    end
    next_cell[CAPACITY-1] = cell_r[CAPACITY-1];

    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins && !keep_r[i]) begin
        cell_nxt[i] = bnd_r[i] ? key_r : prev_cell[i];
      end else if (do_rem && !keep_r[i]) begin
        cell_nxt[i] = next_cell[i];
      end
    end

    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_BITS'(1);
    end

    max_c = (count_nxt == '0) ? '0 : cell_nxt[0];
    res_c.max_key    = KEY_W'(max_c);
    res_c.is_empty   = (count_nxt == '0);
    res_c.held_count = CNT_W'(count_nxt);
    res_c.rejected   = !(do_ins || do_rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EVAL;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      unique case (state_r)
        ST_EVAL: begin
          if (cmd.valid) state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          state_r     <= ST_EVAL;
          count_r     <= count_nxt;
          res_valid_r <= 1'b1;
        end
        default: state_r <= ST_EVAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_r     <= key_in;
      remove_r  <= cmd.is_remove;
      keep_r    <= keep_c;
      bnd_r     <= bnd_c;
      grp_hit_r <= grp_hit_c;
    end
    if (state_r == ST_APPLY) begin
      res_r <= res_c;
      for (int i = 0; i < CAPACITY; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: hw/rtl/deletable_max_priority_queue.sv
// Bounded max priority queue with removal of any key. Each item inserts a
// key or removes one copy of it, and gives exactly one result: the largest
// key held, the count, an empty flag, and a rejected flag for an insert into
// a full store or a removal of an absent key. Keys live in a sorted row of
// CAPACITY cells; the back end handles each item as a parallel compare
// over all cells with a grouped match reduction, then a one-place shift of
// the row, and takes a new item only once it is done with the last one.
// A two-entry queue sits in front: busy rises only when it is full. The
// result strobe out_valid is registered in the back end's apply state, after
// the front queue and the evaluate state, and lasts one cycle; the receiver
// cannot stall it, so results must be taken as they come.
module deletable_max_priority_queue
  import dmpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t head;
  logic pop;
  logic full;

  dmpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_item (in_item),
    .pop       (pop),
    .head      (head),
    .full      (full)
  );

  dmpq_back #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (out_item)
  );

  assign busy = full;

  // the back end takes one item at a time, evaluating then applying it
  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a full queue is drained by the next pop of the back end
  a_busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(busy) && busy) |=> !busy)
    else $error("busy held longer than the back end needs");

  a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_empty) |-> (out_item.max_key == '0))
    else $error("nonzero maximum on an empty store");

endmodule
